/* rtl/core/cdq_pkg.sv */
// cdq_pkg: sizes, command and status codes and the cell control struct
// for the circular deque. No dependencies.
`default_nettype none

package cdq_pkg;

  localparam int DEPTH     = 16;
  localparam int NUM_CELLS = DEPTH - 1;
  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle shift/update controls broadcast to every cell
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cdq_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/cdq_ifs.sv */
// cdq_in_if / cdq_out_if: request and result channels (valid/ready)
// depends on cdq_pkg
`default_nettype none

interface cdq_in_if import cdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] push_byte;

  modport source (output valid, output cmd, output push_byte, input ready);
  modport sink   (input valid, input cmd, input push_byte, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [STAT_W-1:0] status;
  logic              now_empty;
  logic              now_full;

  modport source (output valid, output out_byte, output status,
                  output now_empty, output now_full, input ready);
  modport sink   (input valid, input out_byte, input status,
                  input now_empty, input now_full, output ready);
endinterface

`default_nettype wire

/* rtl/core/circular_deque.sv */
// circular_deque: byte deque of DEPTH-1 entries built as a row of shifting cells
// latency: a result is valid in the cycle after its request is accepted
// throughput: one request per cycle while results are taken; the result register frees as it is taken
// each request is one shift or one cell write along the row of cdq_cell
// reset clears every occupied flag and the result valid; stored bytes are kept
// depends on cdq_pkg, cdq_ifs, cdq_cell
`default_nettype none

module circular_deque import cdq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cdq_in_if.sink     in_ch,
  cdq_out_if.source  out_ch
);

  // the row: cell 0 holds the front byte, occupied cells form one run from 0
  logic [BYTE_W-1:0] cell_byte [NUM_CELLS];
  logic [NUM_CELLS-1:0] occ;
  logic [NUM_CELLS:0]   occ_hi;   // occ with a free cell past the end
  logic [NUM_CELLS:0]   occ_lo;   // occ with an occupied cell before the start

  assign occ_hi = {1'b0, occ};
  assign occ_lo = {occ, 1'b1};

  logic q_empty, q_full;
  assign q_empty = !occ[0];
  assign q_full  = occ[NUM_CELLS-1];

  // request handshake; the result register parts the two sides
  logic out_valid_r;
  logic req_acc;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign req_acc     = in_ch.valid && in_ch.ready;

  // byte held by the last occupied cell, picked by its one-hot marker
  logic [BYTE_W-1:0] rear_byte;
  always_comb begin
    rear_byte = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      rear_byte = rear_byte | (cell_byte[i] & {BYTE_W{occ[i] && !occ_hi[i+1]}});
    end
  end

  // decode the request against the current fill
  cdq_ctl_t          ctl;
  logic [BYTE_W-1:0] res_byte;
  status_t           res_status;
  logic              res_empty, res_full;

  always_comb begin
    ctl        = '0;
    res_byte   = '0;
    res_status = ST_DONE;
    res_empty  = q_empty;
    res_full   = q_full;
    case (in_ch.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (q_full) begin
          res_status = ST_FULL;
        end else begin
          ctl.push_front = (in_ch.cmd == CMD_PUSH_FRONT);
          ctl.push_rear  = (in_ch.cmd == CMD_PUSH_REAR);
          res_empty      = 1'b0;
          // full afterwards when all but the last cell were taken
          res_full       = occ_lo[NUM_CELLS-1];
        end
      end
      CMD_POP_FRONT, CMD_POP_REAR: begin
        if (q_empty) begin
          res_status = ST_EMPTY;
        end else begin
          ctl.pop_front = (in_ch.cmd == CMD_POP_FRONT);
          ctl.pop_rear  = (in_ch.cmd == CMD_POP_REAR);
          res_byte      = (in_ch.cmd == CMD_POP_FRONT) ? cell_byte[0] : rear_byte;
          // empty afterwards when only one byte was held
          res_empty     = !occ_hi[1];
          res_full      = 1'b0;
        end
      end
      CMD_PEEK_FRONT: begin
        if (q_empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_byte = cell_byte[0];
        end
      end
      default: begin
        // unused command: no change, flags report the current fill
      end
    endcase
    if (!req_acc) begin
      ctl = '0;
    end
  end

  // the row of cells, each shifting with its neighbors
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    logic [BYTE_W-1:0] left_byte, right_byte;
    logic              left_occ, right_occ;

    if (g == 0) begin : g_head
      assign left_byte = in_ch.push_byte;
      assign left_occ  = 1'b1;
    end else begin : g_mid
      assign left_byte = cell_byte[g-1];
      assign left_occ  = occ[g-1];
    end

    if (g == NUM_CELLS - 1) begin : g_tail
      assign right_byte = '0;
      assign right_occ  = 1'b0;
    end else begin : g_body
      assign right_byte = cell_byte[g+1];
      assign right_occ  = occ[g+1];
    end

    cdq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .push_byte  (in_ch.push_byte),
      .left_byte  (left_byte),
      .left_occ   (left_occ),
      .right_byte (right_byte),
      .right_occ  (right_occ),
      .byte_q     (cell_byte[g]),
      .occ_q      (occ[g])
    );
  end

  // result register
  logic [BYTE_W-1:0] out_byte_r;
  status_t           out_status_r;
  logic              out_empty_r, out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (req_acc) begin
      out_byte_r   <= res_byte;
      out_status_r <= res_status;
      out_empty_r  <= res_empty;
      out_full_r   <= res_full;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.now_empty = out_empty_r;
  assign out_ch.now_full  = out_full_r;

endmodule

`default_nettype wire

/* rtl/core/cdq_cell.sv */
// cdq_cell: one deque position, a byte and an occupied flag
// depends on cdq_pkg; neighbors are wired up by circular_deque
`default_nettype none

module cdq_cell import cdq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cdq_ctl_t          ctl,
  input  wire logic [BYTE_W-1:0] push_byte,
  input  wire logic [BYTE_W-1:0] left_byte,
  input  wire logic              left_occ,
  input  wire logic [BYTE_W-1:0] right_byte,
  input  wire logic              right_occ,
  output logic [BYTE_W-1:0]      byte_q,
  output logic                   occ_q
);

  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              occ_r, occ_nxt;

  always_comb begin
    byte_nxt = byte_r;
    occ_nxt  = occ_r;
    if (ctl.push_front) begin
      byte_nxt = left_byte;
      occ_nxt  = left_occ;
    end else if (ctl.push_rear) begin
      // first free cell after the occupied run
      if (!occ_r && left_occ) begin
        byte_nxt = push_byte;
        occ_nxt  = 1'b1;
      end
    end else if (ctl.pop_front) begin
      byte_nxt = right_byte;
      occ_nxt  = right_occ;
    end else if (ctl.pop_rear) begin
      if (occ_r && !right_occ) begin
        occ_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;
  assign occ_q  = occ_r;

endmodule

`default_nettype wire

/* rtl/core/cdq_checker.sv */
// cdq_checker: port-level checks on circular_deque, attached by bind
// depends on cdq_pkg and circular_deque
`default_nettype none

module cdq_checker import cdq_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic [STAT_W-1:0] status,
  input wire logic              now_empty,
  input wire logic              now_full
);

  // a held result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // every accepted request gives a result in the next cycle
  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request gave no result");

  // never empty and full together
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(now_empty && now_full))
    else $error("empty and full both set");

  // a refusal matches the reported fill and carries no byte
  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FULL |-> now_full && out_byte == '0)
    else $error("full refusal inconsistent");

  a_refuse_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_EMPTY |-> now_empty && out_byte == '0)
    else $error("empty refusal inconsistent");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .status    (out_ch.status),
  .now_empty (out_ch.now_empty),
  .now_full  (out_ch.now_full)
);

`default_nettype wire

/* bench/circular_deque_tb.sv */
// circular_deque_tb: self-checking bench for the byte deque, with a mirror of the ring
// and random request and result stalls; depends on cdq_pkg, cdq_ifs and circular_deque
`default_nettype none

module circular_deque_tb import cdq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // commands outside the five defined ones: accepted and answered, change nothing
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  // cycles with no handshake on either channel before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // random requests per half phase
  localparam int HALF_PHASE = 215;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    status_t           status;
    logic              now_empty;
    logic              now_full;
  } deque_answer_t;

  // mirror of the ring: predicts the answer to every accepted request and
  // holds it until the block delivers its own
  class deque_mirror;
    logic [BYTE_W-1:0] ring [DEPTH];
    int unsigned head;  // free slot just before the first byte
    int unsigned tail;  // slot of the last byte
    deque_answer_t answers_due[$];
    int mismatches;
    int n_checked;
    int n_done;
    int n_refused_full;
    int n_refused_empty;
    int n_spare;

    function new();
      head = 0;
      tail = 0;
      mismatches = 0;
      n_checked = 0;
      n_done = 0;
      n_refused_full = 0;
      n_refused_empty = 0;
      n_spare = 0;
    endfunction

    function bit is_empty();
      return head == tail;
    endfunction

    function bit is_full();
      return head == (tail + 1) % DEPTH;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data);
      deque_answer_t a;
      a.out_byte = '0;
      a.status = ST_DONE;
      case (cmd)
        CMD_PUSH_FRONT: begin
          if (is_full()) begin
            a.status = ST_FULL;
          end else begin
            ring[head] = data;
            head = (head + DEPTH - 1) % DEPTH;
          end
        end
        CMD_PUSH_REAR: begin
          if (is_full()) begin
            a.status = ST_FULL;
          end else begin
            tail = (tail + 1) % DEPTH;
            ring[tail] = data;
          end
        end
        CMD_POP_FRONT: begin
          if (is_empty()) begin
            a.status = ST_EMPTY;
          end else begin
            head = (head + 1) % DEPTH;
            a.out_byte = ring[head];
          end
        end
        CMD_POP_REAR: begin
          if (is_empty()) begin
            a.status = ST_EMPTY;
          end else begin
            a.out_byte = ring[tail];
            tail = (tail + DEPTH - 1) % DEPTH;
          end
        end
        CMD_PEEK_FRONT: begin
          if (is_empty()) a.status = ST_EMPTY;
          else a.out_byte = ring[(head + 1) % DEPTH];
        end
        default: n_spare++;
      endcase
      a.now_empty = is_empty();
      a.now_full = is_full();
      case (a.status)
        ST_FULL:  n_refused_full++;
        ST_EMPTY: n_refused_empty++;
        default:  n_done++;
      endcase
      answers_due.push_back(a);
    endfunction

    function void check_result(deque_answer_t got);
      deque_answer_t want;
      n_checked++;
      if (answers_due.size() == 0) begin
        $display("%0t: result with none due: byte %02h status %0d empty %0b full %0b",
                 $time, got.out_byte, got.status, got.now_empty, got.now_full);
        mismatches++;
        return;
      end
      want = answers_due.pop_front();
      if (got.out_byte !== want.out_byte || got.status !== want.status ||
          got.now_empty !== want.now_empty || got.now_full !== want.now_full) begin
        $display("%0t: mismatch exp byte %02h status %0d empty %0b full %0b, got %02h %0d %0b %0b",
                 $time, want.out_byte, want.status, want.now_empty, want.now_full,
                 got.out_byte, got.status, got.now_empty, got.now_full);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   stall_cycles;
  deque_mirror mirror;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: the receiver stalls at random, one decision per cycle
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // both channels are sampled at the rising edge; the result is checked
  // before the request is noted, since a result never belongs to the same edge
  always @(posedge clk) begin : watch
    deque_answer_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte = out_ch.out_byte;
        got.status = status_t'(out_ch.status);
        got.now_empty = out_ch.now_empty;
        got.now_full = out_ch.now_full;
        mirror.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) mirror.note_request(in_ch.cmd, in_ch.push_byte);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // watchdog: nothing moved for too long
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no handshake for %0d cycles, %0d results still due",
             $time, STALL_LIMIT, mirror.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  // one request; idle cycles before it follow send_idle_pct, valid stays
  // high after acceptance until the next negedge decides otherwise
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      in_ch.cmd = CMD_W'($urandom);
      in_ch.push_byte = BYTE_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.cmd = cmd;
    in_ch.push_byte = data;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // sender holds off until every answer has come back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (mirror.pending() != 0) @(negedge clk);
  endtask

  // random traffic in runs that lean toward filling, draining or neither,
  // so the deque keeps swinging between empty and full; spare commands
  // are sprinkled in and do not count
  task automatic run_random(input int n);
    int sent;
    int run_left;
    int push_pct;
    logic [CMD_W-1:0] cmd;
    sent = 0;
    run_left = 0;
    push_pct = 50;
    while (sent < n) begin
      if (run_left == 0) begin
        run_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 50;
        endcase
      end
      if ($urandom_range(99) < 4) begin
        cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      end else if ($urandom_range(99) < push_pct) begin
        cmd = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
      end else begin
        case ($urandom_range(2))
          0:       cmd = CMD_POP_FRONT;
          1:       cmd = CMD_POP_REAR;
          default: cmd = CMD_PEEK_FRONT;
        endcase
      end
      send_request(cmd, BYTE_W'($urandom));
      if (cmd <= CMD_PEEK_FRONT) begin
        sent++;
        run_left--;
      end
    end
  endtask

  initial begin
    mirror = new();
    stall_cycles = 0;
    send_idle_pct = 29;
    recv_idle_pct = 52;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_PUSH_FRONT;
    in_ch.push_byte = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // refusals on the empty deque and a spare command with nothing stored
    send_request(CMD_POP_FRONT, 8'h5A);
    send_request(CMD_POP_REAR, 8'hA5);
    send_request(CMD_PEEK_FRONT, 8'hFF);
    send_request(CMD_SPARE_LO, 8'hFF);
    // extreme bytes at both ends, front push wraps the head below slot 0
    send_request(CMD_PUSH_FRONT, 8'h00);
    send_request(CMD_PUSH_REAR, 8'hFF);
    send_request(CMD_PEEK_FRONT, 8'h00);
    send_request(CMD_POP_REAR, 8'h00);
    send_request(CMD_POP_FRONT, 8'h00);
    // fill to capacity from both ends, then refused pushes and a spare
    // command while full
    for (int i = 0; i < DEPTH - 1; i++) begin
      send_request((i % 2) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, BYTE_W'(i * 8'h11));
    end
    send_request(CMD_PUSH_REAR, 8'h33);
    send_request(CMD_PUSH_FRONT, 8'hCC);
    send_request(CMD_SPARE_HI, 8'h00);

    // phase one: sender idles less than receiver
    run_random(HALF_PHASE);
    wait_drained();
    run_random(HALF_PHASE);
    wait_drained();

    // phase two: the other way round
    send_idle_pct = 52;
    recv_idle_pct = 29;
    run_random(HALF_PHASE);
    wait_drained();
    run_random(HALF_PHASE);
    wait_drained();

    // phase three: both sides at full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(HALF_PHASE);
    wait_drained();
    run_random(HALF_PHASE);
    wait_drained();

    // let the clock run on to catch any stray result
    repeat (8) @(posedge clk);

    $display("covered %0d answers: %0d completed, %0d pushes refused on a full deque,",
             mirror.n_checked, mirror.n_done, mirror.n_refused_full);
    $display("%0d pops or peeks refused on an empty one, %0d spare commands; %0d mismatches",
             mirror.n_refused_empty, mirror.n_spare, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
